// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check a property at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- hdl/bew_pkg.sv -----
package bew_pkg;

    localparam int PIX_W           = 8;
    localparam int DIM_W           = 12;
    localparam int RAD_W           = 2;
    localparam int ROW_W           = 11;
    localparam int MAX_FRAME_LINES = 2048;
    localparam int PEND_W          = 14;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_VALUE   = 3'd4;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [RAD_W-1:0] RST_RADIUS       = 2'd1;
    localparam logic [PIX_W-1:0] RST_FLAG_VALUE   = 8'd0;

    localparam logic [PIX_W-1:0] OUT_ERODED = 8'd0;
    localparam logic [PIX_W-1:0] OUT_KEPT   = 8'd255;

    typedef struct packed {
        logic row_zero;
        logic col_zero;
        logic last;
    } t_pos_flags;

endpackage

// ----- hdl/bew_run_mem.sv -----
module bew_run_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 3
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/bew_raster_pos.sv -----
module bew_raster_pos #(
    parameter int COL_W = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [bew_pkg::DIM_W-1:0] i_width,
    input  logic [bew_pkg::DIM_W-1:0] i_height,
    output logic [COL_W-1:0]        o_col,
    output bew_pkg::t_pos_flags     o_flags
);

    import bew_pkg::*;

    localparam int CMP_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [CMP_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             col_wrap;
    logic             row_wrap;

    assign col_inc  = CMP_W'(r_col) + CMP_W'(1);
    assign row_inc  = DIM_W'(r_row) + DIM_W'(1);
    assign col_wrap = col_inc >= CMP_W'(i_width);
    assign row_wrap = row_inc >= i_height;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col            = r_col;
    assign o_flags.row_zero = (r_row == '0);
    assign o_flags.col_zero = (r_col == '0);
    assign o_flags.last     = col_wrap && row_wrap;

endmodule

// ----- hdl/binary_erosion_window_unit.sv -----
// Streaming binary erosion over a rectangular window, one mask pixel per beat.
// Input channel: i_in_valid/o_in_ready with i_pixel_value and i_flush. A pixel
// beat updates the column run of its column and the row run; a flush beat
// carries no pixel and only pushes out one pending result (always 255).
// Output channel: o_out_valid/i_out_ready with o_out_value (0 when the whole
// window equals the flag value, else 255) and o_frame_end on the frame's last
// pixel. Results lag the pixel stream by radius_y lines plus radius_x pixels;
// send that many flush beats to drain the tail of a frame.
// Config channel: i_cfg_valid/o_cfg_ready (always ready), i_cfg_index picks the
// register (width, height, radius_x, radius_y, flag value); write only while
// idle.
// Pipeline: a beat is registered into the pixel stage (the column run memory
// read is registered there too), and its result into the output register.
// One beat per cycle is sustained while the output is not stalled; the column
// run memory has one write and one read port.
// Reset clears positions, runs and the pending count; the column run memory
// is not cleared, as row 0 never reads it. If the receiver stalls, the output
// register holds and the pixel stage stalls only when it has a result to hand
// over.
module binary_erosion_window_unit #(
    parameter int MAX_LINE_WIDTH = 2048,
    parameter int MAX_RADIUS     = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bew_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bew_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bew_pkg::PIX_W-1:0]        i_pixel_value,
    input  logic                             i_flush,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bew_pkg::PIX_W-1:0]        o_out_value,
    output logic                             o_frame_end
);

    import bew_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    localparam int RUN_W = $clog2(2 * MAX_RADIUS + 2);
    localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(2 * MAX_RADIUS + 1);

    // configuration
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [RAD_W-1:0] r_radius_x;
    logic [RAD_W-1:0] r_radius_y;
    logic [PIX_W-1:0] r_flag_value;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [RAD_W-1:0] rx_eff;
    logic [RAD_W-1:0] ry_eff;
    logic [PEND_W-1:0] delay;
    logic [RUN_W-1:0] thr_x;
    logic [RUN_W-1:0] thr_y;

    // pixel stage
    logic             r_s1_valid;
    logic             r_s1_flush;
    logic             r_s1_match;
    logic             r_s1_row_zero;
    logic             r_s1_col_zero;
    logic [COL_W-1:0] r_s1_col;
    logic             r_byp;
    logic [RUN_W-1:0] r_byp_data;
    logic [RUN_W-1:0] r_qrun;
    logic [PEND_W-1:0] r_pend;
    logic [RUN_W-1:0] n_qrun;
    logic [PEND_W-1:0] n_pend;
    logic [RUN_W-1:0] rd_data;
    logic [RUN_W-1:0] crun_prev;
    logic [RUN_W-1:0] crun;
    logic [RUN_W-1:0] q_base;
    logic             col_ok;
    logic             all_flag;
    logic [PEND_W:0]  pend_inc;
    logic             emit_px;
    logic             s1_emits;
    logic             s1_adv;
    logic             out_free;
    logic             in_accept;
    logic             mem_we;

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_value;
    logic             r_frame_end;

    // raster positions
    logic [COL_W-1:0] in_col;
    t_pos_flags       in_flags;
    logic [COL_W-1:0] out_col;
    t_pos_flags       out_flags;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_radius_x     <= RST_RADIUS;
            r_radius_y     <= RST_RADIUS;
            r_flag_value   <= RST_FLAG_VALUE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                REG_RADIUS_X:     r_radius_x     <= i_cfg_data[RAD_W-1:0];
                REG_RADIUS_Y:     r_radius_y     <= i_cfg_data[RAD_W-1:0];
                REG_FLAG_VALUE:   r_flag_value   <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp out-of-range settings
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(r_frame_width) > MAX_LINE_WIDTH) begin
            w_eff = DIM_W'(MAX_LINE_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (32'(r_frame_height) > MAX_FRAME_LINES) begin
            h_eff = DIM_W'(MAX_FRAME_LINES);
        end else begin
            h_eff = r_frame_height;
        end
        rx_eff = (32'(r_radius_x) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_radius_x;
        ry_eff = (32'(r_radius_y) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_radius_y;
    end

    assign delay = PEND_W'(ry_eff) * PEND_W'(w_eff) + PEND_W'(rx_eff);
    assign thr_x = RUN_W'({rx_eff, 1'b1});
    assign thr_y = RUN_W'({ry_eff, 1'b1});

    bew_raster_pos #(
        .COL_W (COL_W)
    ) u_in_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_accept && !i_flush),
        .i_width  (w_eff),
        .i_height (h_eff),
        .o_col    (in_col),
        .o_flags  (in_flags)
    );

    bew_raster_pos #(
        .COL_W (COL_W)
    ) u_out_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv && s1_emits),
        .i_width  (w_eff),
        .i_height (h_eff),
        .o_col    (out_col),
        .o_flags  (out_flags)
    );

    bew_run_mem #(
        .DEPTH  (MAX_LINE_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (RUN_W)
    ) u_run_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_s1_col),
        .i_wr_data (crun),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_col),
        .o_rd_data (rd_data)
    );

    // column run and row run of the pixel in the stage
    always_comb begin
        if (r_s1_row_zero) begin
            crun_prev = '0;
        end else if (r_byp) begin
            crun_prev = r_byp_data;
        end else begin
            crun_prev = rd_data;
        end
        if (!r_s1_match) begin
            crun = '0;
        end else if (crun_prev >= RUN_CAP) begin
            crun = RUN_CAP;
        end else begin
            crun = crun_prev + RUN_W'(1);
        end
        col_ok = crun >= thr_y;
        q_base = r_s1_col_zero ? '0 : r_qrun;
        if (!col_ok) begin
            n_qrun = '0;
        end else if (q_base >= RUN_CAP) begin
            n_qrun = RUN_CAP;
        end else begin
            n_qrun = q_base + RUN_W'(1);
        end
        all_flag = n_qrun >= thr_x;
    end

    assign pend_inc = {1'b0, r_pend} + (PEND_W + 1)'(1);
    assign emit_px  = pend_inc > {1'b0, delay};
    assign s1_emits = r_s1_valid && (r_s1_flush ? (r_pend != '0) : emit_px);
    assign out_free = !r_out_valid || i_out_ready;
    assign s1_adv   = r_s1_valid && (!s1_emits || out_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;
    assign mem_we     = s1_adv && !r_s1_flush;

    always_comb begin
        n_pend = r_pend;
        if (s1_adv) begin
            if (r_s1_flush) begin
                if (r_pend != '0) begin
                    n_pend = r_pend - PEND_W'(1);
                end
            end else if (!emit_px) begin
                n_pend = pend_inc[PEND_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_qrun      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (mem_we) begin
                r_qrun <= n_qrun;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && s1_emits) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the pixel stage and the output register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_flush    <= i_flush;
            r_s1_match    <= (i_pixel_value == r_flag_value);
            r_s1_row_zero <= in_flags.row_zero;
            r_s1_col_zero <= in_flags.col_zero;
            r_s1_col      <= in_col;
            // forward the run being written when it targets the column read
            r_byp         <= mem_we && (r_s1_col == in_col);
            r_byp_data    <= crun;
        end
        if (s1_adv && s1_emits) begin
            r_out_value <= (!r_s1_flush && all_flag) ? OUT_ERODED : OUT_KEPT;
            r_frame_end <= out_flags.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_frame_end = r_frame_end;

endmodule

// ----- hdl/bew_port_checker.sv -----
`include "assert_macros.svh"

module bew_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [bew_pkg::PIX_W-1:0]     o_out_value,
    input logic                          o_frame_end
);

    import bew_pkg::*;

    logic out_stall;

    assign out_stall = o_out_valid && !i_out_ready;

    // a stalled result beat stays
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out_valid)

    // a stalled result beat keeps its payload
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable({o_out_value, o_frame_end}))

    // input back-pressure only comes from a stalled output register
    `ASSERT_RST(a_ready_cause, i_clk, i_rst_n, !o_in_ready |-> out_stall)

    // reset drops any result
    `ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind binary_erosion_window_unit bew_port_checker u_bew_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_value (o_out_value),
    .o_frame_end (o_frame_end)
);
